/* rtl/stx_etx_frame_builder_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the STX/ETX frame builder
// Shared helpers that write clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef STX_ETX_FRAME_BUILDER_DEFINES_SVH
`define STX_ETX_FRAME_BUILDER_DEFINES_SVH

// The antecedent holds in the same cycle as the consequent.
`define SEFB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define SEFB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/sefb_pkg.sv */
// ----------------------------------------------------------------------------
// sefb_pkg
// Constants, types and helpers shared by the frame builder modules.
// ----------------------------------------------------------------------------
package sefb_pkg;

    localparam logic [7:0] FRAME_STX = 8'h02;
    localparam logic [7:0] FRAME_ETX = 8'h03;
    localparam logic [7:0] FRAME_CR  = 8'h0D;
    localparam logic [7:0] BYTE_MASK = 8'hFF;

    localparam logic [7:0] ASCII_ZERO   = 8'h30;
    localparam logic [7:0] ASCII_A_LESS = 8'h37;
    localparam logic [3:0] NIBBLE_TEN   = 4'd10;

    typedef enum logic [2:0] {
        POS_STX,
        POS_DATA,
        POS_ETX,
        POS_HEX_HI,
        POS_HEX_LO,
        POS_CR
    } sefb_pos_t;

    typedef struct packed {
        logic [7:0] payload;
        logic       has_stx;
        logic       has_tail;
        logic [7:0] checksum;
    } sefb_item_t;

    function automatic logic [7:0] hex_digit(input logic [3:0] nibble);
        logic [7:0] code;
        if (nibble < NIBBLE_TEN)
        begin
            code = ASCII_ZERO + {4'd0, nibble};
        end
        else
        begin
            code = ASCII_A_LESS + {4'd0, nibble};
        end
        return code & BYTE_MASK;
    endfunction

endpackage

/* rtl/sefb_emitter.sv */
// ----------------------------------------------------------------------------
// sefb_emitter
// Holds one prepared item and sends its frame bytes one per cycle, while the
// receiver takes them, through a registered output stage.
// ----------------------------------------------------------------------------
`include "stx_etx_frame_builder_defines.svh"

module sefb_emitter (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  sefb_pkg::sefb_item_t item,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         out_byte,
    output logic               out_end
);
    import sefb_pkg::*;

    logic       a_valid_reg;
    logic       a_valid_next;
    sefb_item_t item_reg;
    sefb_pos_t  pos_reg;
    sefb_pos_t  pos_next;
    logic       o_valid_reg;
    logic       o_valid_next;
    logic [7:0] o_data_reg;
    logic       o_last_reg;

    logic       emit;
    logic       final_pos;
    logic       load;
    sefb_pos_t  pos_step;
    logic [7:0] byte_sel;

    assign emit      = a_valid_reg && (!o_valid_reg || out_ready);
    assign final_pos = (pos_reg == POS_CR) || ((pos_reg == POS_DATA) && !item_reg.has_tail);
    assign in_ready  = !a_valid_reg || (emit && final_pos);
    assign load      = in_valid && in_ready;

    always_comb
    begin
        unique case (pos_reg)
            POS_STX:
            begin
                byte_sel = FRAME_STX;
                pos_step = POS_DATA;
            end
            POS_DATA:
            begin
                byte_sel = item_reg.payload;
                pos_step = POS_ETX;
            end
            POS_ETX:
            begin
                byte_sel = FRAME_ETX;
                pos_step = POS_HEX_HI;
            end
            POS_HEX_HI:
            begin
                byte_sel = hex_digit(item_reg.checksum[7:4]);
                pos_step = POS_HEX_LO;
            end
            POS_HEX_LO:
            begin
                byte_sel = hex_digit(item_reg.checksum[3:0]);
                pos_step = POS_CR;
            end
            POS_CR:
            begin
                byte_sel = FRAME_CR;
                pos_step = POS_STX;
            end
            default:
            begin
                byte_sel = FRAME_CR;
                pos_step = POS_STX;
            end
        endcase
    end

    always_comb
    begin
        a_valid_next = a_valid_reg;
        pos_next     = pos_reg;
        priority if (load)
        begin
            a_valid_next = 1'b1;
            pos_next     = item.has_stx ? POS_STX : POS_DATA;
        end
        else if (emit && final_pos)
        begin
            a_valid_next = 1'b0;
        end
        else if (emit)
        begin
            pos_next = pos_step;
        end

        o_valid_next = o_valid_reg;
        priority if (emit)
        begin
            o_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            o_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            pos_reg     <= POS_STX;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            pos_reg     <= pos_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item;
        end
        if (emit)
        begin
            o_data_reg <= byte_sel;
            o_last_reg <= (pos_reg == POS_CR);
        end
    end

    assign out_valid = o_valid_reg;
    assign out_byte  = o_data_reg;
    assign out_end   = o_last_reg;

    `SEFB_ASSERT_SAME(a_end_is_cr, o_valid_reg && o_last_reg, o_data_reg == FRAME_CR, "frame end not on CR")
    `SEFB_ASSERT_SAME(a_tail_only_with_last, a_valid_reg && !item_reg.has_tail, pos_reg == POS_STX || pos_reg == POS_DATA, "tail position without last byte")
    `SEFB_ASSERT_NEXT(a_load_holds_item, load, a_valid_reg, "accepted item not held")
    `SEFB_ASSERT_NEXT(a_emit_fills_output, emit, o_valid_reg, "emitted byte not presented")

endmodule

/* rtl/stx_etx_frame_builder.sv */
// ----------------------------------------------------------------------------
// stx_etx_frame_builder
// Wraps a stream of payload bytes in STX/ETX frames with an ASCII hex checksum.
// ----------------------------------------------------------------------------
// Payload bytes enter on s_axis, with tlast on the final byte of a frame.
// Frame bytes leave on m_axis: STX, the payload, ETX, two uppercase hex
// digits of the checksum (sum of STX, payload and ETX, modulo 256) and CR,
// with tlast on the CR.
// Each item is held in one register and its frame bytes are sent one per
// cycle while the receiver takes them, through a registered output stage,
// so the first byte passes the item register and then the output register.
// A middle byte sends only itself, the first byte of a frame is preceded
// by STX and the last byte is followed by ETX, the two hex digits and CR;
// the output stage carries a single byte per cycle.
// A new item is taken if none is held or as the held item sends its last byte.
// When the receiver stalls, the output byte holds and s_axis_tready falls
// once the held item can make no progress.
// Reset empties both stages, clears the running checksum and closes any
// open frame.
// ----------------------------------------------------------------------------
`include "stx_etx_frame_builder_defines.svh"

module stx_etx_frame_builder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] payload_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] frame_byte
    output logic       m_axis_tlast
);
    import sefb_pkg::*;

    logic [7:0] running_sum_reg;
    logic [7:0] running_sum_next;
    logic       in_frame_reg;
    logic       in_frame_next;

    logic       accept;
    logic [7:0] base_sum;
    logic [7:0] payload_sum;
    sefb_item_t item;

    assign accept      = s_axis_tvalid && s_axis_tready;
    assign base_sum    = in_frame_reg ? running_sum_reg : FRAME_STX;
    assign payload_sum = base_sum + s_axis_tdata;

    always_comb
    begin
        item.payload  = s_axis_tdata;
        item.has_stx  = !in_frame_reg;
        item.has_tail = s_axis_tlast;
        item.checksum = payload_sum + FRAME_ETX;

        running_sum_next = running_sum_reg;
        in_frame_next    = in_frame_reg;
        if (accept)
        begin
            running_sum_next = s_axis_tlast ? 8'd0 : payload_sum;
            in_frame_next    = !s_axis_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_sum_reg <= 8'd0;
            in_frame_reg    <= 1'b0;
        end
        else
        begin
            running_sum_reg <= running_sum_next;
            in_frame_reg    <= in_frame_next;
        end
    end

    sefb_emitter u_emitter (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .item      (item),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .out_end   (m_axis_tlast)
    );

    `SEFB_ASSERT_SAME(a_closed_sum_zero, !in_frame_reg, running_sum_reg == 8'd0, "sum not cleared outside a frame")
    `SEFB_ASSERT_NEXT(a_last_closes_frame, accept && s_axis_tlast, !in_frame_reg, "frame left open after last byte")
    `SEFB_ASSERT_NEXT(a_byte_opens_frame, accept && !s_axis_tlast, in_frame_reg, "frame not open after middle byte")

endmodule
